### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the checker modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

### rtl/nisr_pkg.sv
// ----------------------------------------------------------------------------
// nisr_pkg
// Constants and types for the Newton integer square root block
// ----------------------------------------------------------------------------
package nisr_pkg;

  // default radicand width
  localparam int RadicandWidth = 32;

  // result width and saturation value
  localparam int RootWidth = 16;
  localparam int RootMax   = 65535;

  // upper bound on Newton rounds for one item
  localparam int RoundLimit = 160;
  localparam int RoundWidth = $clog2(RoundLimit);

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_LAUNCH,
    S_DIV,
    S_TEST,
    S_DONE
  } nisr_state_t;

endpackage

### rtl/newton_integer_square_root_top.sv
// ----------------------------------------------------------------------------
// newton_integer_square_root_top
// Integer square root by Newton iteration on a shared bit-serial divider
// ----------------------------------------------------------------------------
// Pulse start while busy is low to hand in a radicand on in_value. The block
// starts from the radicand halved, divides the radicand by the estimate and
// replaces the estimate by the floor average of estimate and quotient until
// the two lie within one of each other or the round limit is hit; the last
// quotient, saturated at 65535, comes out on out_root for exactly one cycle
// with out_valid high, and the receiver must take it then. Each Newton round
// passes through launch, the restoring divider (one quotient bit per cycle),
// its done pulse and the test, and the result state follows the last round.
// A 32-bit radicand needs up to about twenty rounds; radicands of zero and
// one skip the rounds and go straight to the result state.
// busy stays high from the accepting edge until the result cycle ends.
module newton_integer_square_root_top #(
  parameter int RADICAND_WIDTH = nisr_pkg::RadicandWidth
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [RADICAND_WIDTH-1:0]      in_value,
  output logic                           out_valid,
  output logic [nisr_pkg::RootWidth-1:0] out_root
);

  localparam int W  = RADICAND_WIDTH;
  localparam int RW = nisr_pkg::RoundWidth;
  localparam int XW = (W > nisr_pkg::RootWidth) ? W : nisr_pkg::RootWidth;

  nisr_pkg::nisr_state_t state_r, state_nxt;

  logic [RW-1:0] round_r, round_nxt;
  logic [W-1:0]  val_r, val_nxt;
  logic [W-1:0]  est_r, est_nxt;
  logic [W-1:0]  quo_r, quo_nxt;

  logic          div_start;
  logic          div_done;
  logic [W-1:0]  div_quo;
  logic [W-1:0]  est_safe;
  logic [W-1:0]  gap;
  logic [W-1:0]  avg;
  logic [XW-1:0] quo_x;

  // shared divider: radicand over current estimate
  nisr_div #(
    .RADICAND_WIDTH(W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (val_r),
    .divisor  (est_safe),
    .done     (div_done),
    .quotient (div_quo)
  );

  // estimate guard, distance and overflow-free floor average
  always_comb begin
    est_safe = (est_r == '0) ? W'(1) : est_r;
    gap      = (est_r > quo_r) ? (est_r - quo_r) : (quo_r - est_r);
    avg      = (est_r >> 1) + (quo_r >> 1) + W'(est_r[0] & quo_r[0]);
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    round_nxt = round_r;
    val_nxt   = val_r;
    est_nxt   = est_r;
    quo_nxt   = quo_r;
    div_start = 1'b0;
    unique case (state_r)
      nisr_pkg::S_IDLE: begin
        if (start) begin
          val_nxt   = in_value;
          est_nxt   = in_value >> 1;
          quo_nxt   = in_value;
          round_nxt = '0;
          // zero and one are their own roots
          if (in_value <= W'(1)) begin
            state_nxt = nisr_pkg::S_DONE;
          end else begin
            state_nxt = nisr_pkg::S_LAUNCH;
          end
        end
      end
      nisr_pkg::S_LAUNCH: begin
        div_start = 1'b1;
        est_nxt   = est_safe;
        state_nxt = nisr_pkg::S_DIV;
      end
      nisr_pkg::S_DIV: begin
        if (div_done) begin
          quo_nxt   = div_quo;
          state_nxt = nisr_pkg::S_TEST;
        end
      end
      nisr_pkg::S_TEST: begin
        if ((gap <= W'(1)) || (round_r == RW'(nisr_pkg::RoundLimit - 1))) begin
          state_nxt = nisr_pkg::S_DONE;
        end else begin
          est_nxt   = avg;
          round_nxt = round_r + RW'(1);
          state_nxt = nisr_pkg::S_LAUNCH;
        end
      end
      nisr_pkg::S_DONE: begin
        state_nxt = nisr_pkg::S_IDLE;
      end
      default: begin
        state_nxt = nisr_pkg::S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nisr_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    round_r <= round_nxt;
    val_r   <= val_nxt;
    est_r   <= est_nxt;
    quo_r   <= quo_nxt;
  end

  // result with saturation to the root width
  assign quo_x     = XW'(quo_r);
  assign out_root  = (quo_x > XW'(nisr_pkg::RootMax)) ?
                     nisr_pkg::RootWidth'(nisr_pkg::RootMax) :
                     quo_x[nisr_pkg::RootWidth-1:0];
  assign out_valid = (state_r == nisr_pkg::S_DONE);
  assign busy      = (state_r != nisr_pkg::S_IDLE);

endmodule

### rtl/nisr_div.sv
// ----------------------------------------------------------------------------
// nisr_div
// Restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module nisr_div #(
  parameter int RADICAND_WIDTH = nisr_pkg::RadicandWidth
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [RADICAND_WIDTH-1:0] dividend,
  input  logic [RADICAND_WIDTH-1:0] divisor,
  output logic                      done,
  output logic [RADICAND_WIDTH-1:0] quotient
);

  localparam int W  = RADICAND_WIDTH;
  localparam int CW = $clog2(W);

  logic          run_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [W-1:0]  rem_r;
  logic [W-1:0]  acc_r;
  logic [W-1:0]  dvs_r;

  logic [W:0]    trial;
  logic [W:0]    diff;
  logic          q_bit;
  logic [W-1:0]  rem_nxt;

  // trial subtract of the divisor from the shifted partial remainder
  always_comb begin
    trial   = {rem_r, acc_r[W-1]};
    diff    = trial - {1'b0, dvs_r};
    q_bit   = (trial >= {1'b0, dvs_r});
    rem_nxt = q_bit ? diff[W-1:0] : trial[W-1:0];
  end

  // step counter and completion pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // remainder and dividend/quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      acc_r <= dividend;
      dvs_r <= divisor;
    end else if (run_r) begin
      rem_r <= rem_nxt;
      acc_r <= {acc_r[W-2:0], q_bit};
    end
  end

  assign done     = done_r;
  assign quotient = acc_r;

endmodule

### rtl/nisr_checker.sv
// ----------------------------------------------------------------------------
// nisr_checker
// Port-level checks for the Newton integer square root block
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nisr_checker #(
  parameter int RADICAND_WIDTH = nisr_pkg::RadicandWidth
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           start,
  input logic                           busy,
  input logic [RADICAND_WIDTH-1:0]      in_value,
  input logic                           out_valid,
  input logic [nisr_pkg::RootWidth-1:0] out_root
);

  logic in_xfer;
  logic small_xfer;

  // an input transfer this cycle
  assign in_xfer = start && !busy;

  // an input transfer of zero or one
  assign small_xfer = in_xfer && (in_value <= RADICAND_WIDTH'(1));

  // an accepted item keeps the block busy on the next cycle
  `ASSERT_NXT(a_accept_busy, clk, rst_n, in_xfer, busy)

  // a result only appears while an item is in flight
  `ASSERT_IMP(a_result_busy, clk, rst_n, out_valid, busy)

  // the block is free right after its result
  `ASSERT_NXT(a_result_free, clk, rst_n, out_valid, !busy && !out_valid)

  // no early result: on the cycle after an accepted item, any result is a root of zero or one
  `ASSERT_NXT(a_no_early, clk, rst_n, in_xfer, !out_valid || (out_root <= 16'd1))

  // zero and one come straight back as their own roots
  `ASSERT_NXT(a_small_root, clk, rst_n, small_xfer, out_valid && (out_root <= 16'd1))

endmodule

bind newton_integer_square_root_top nisr_checker #(
  .RADICAND_WIDTH(RADICAND_WIDTH)
) u_nisr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_value  (in_value),
  .out_valid (out_valid),
  .out_root  (out_root)
);
